// ===== hdl/swerm_pkg.sv =====
// shared types and constants of the sliding window event rate meter
package swerm_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_DECIDE,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_POST,
    ST_MIX_OLD,
    ST_MIX_NEW,
    ST_MIX_SUM,
    ST_DONE
  } state_t;

  typedef enum logic {
    MODE_WINDOW,
    MODE_SESSION
  } rate_mode_t;

  localparam logic OP_RECORD  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SERVICES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_RATE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 2'd3;

  localparam int WS_W   = 12;
  localparam int MS_W   = 9;
  localparam int RATE_W = 32;
  localparam int SW_W   = 17;
  localparam int TS_W   = 32;
  localparam int CNT_W  = 32;

  localparam logic [WS_W-1:0]   WINDOW_SECONDS_RST   = 12'd10;
  localparam logic [MS_W-1:0]   MIN_SERVICES_RST     = 9'd3;
  localparam logic [RATE_W-1:0] DEFAULT_RATE_RST     = 32'd65536;
  localparam logic [SW_W-1:0]   SMOOTHING_WEIGHT_RST = 17'd19661;

  localparam int MS_PER_SEC_W = 10;
  localparam logic [MS_PER_SEC_W-1:0] MS_PER_SEC = 10'd1000;
  localparam int LIM_W = WS_W + MS_PER_SEC_W;

  // x * 1000 before the q16 shift
  localparam int PROD_W = CNT_W + MS_PER_SEC_W;
  localparam int FRAC_W = 16;
  localparam int DIV_BITS = 32;
  localparam int DIV_CNT_W = 5;

  localparam logic [SW_W-1:0] WEIGHT_ONE = 17'h10000;
  localparam int MIX_W = SW_W + RATE_W + 1;
  localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;

endpackage

// ===== hdl/swerm_ram.sv =====
// generic single write port ram with registered read
module swerm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sliding_window_event_rate_meter.sv =====
// sliding window event rate meter top level
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   in       | in_valid / in_ready    | operation, timestamp_ms
//   out      | out_valid / out_ready  | rate, event_count, reliable, session_ms
//   cfg      | cfg_write (no wait)    | cfg_index, cfg_data
//
// one request at a time; a restart goes straight to its result, while a record
// scans the ring with one ring read per cycle (a full ring drops its oldest stamp
// unread), then runs a 32 step radix-2 divider and a blend over ST_MIX_OLD,
// ST_MIX_NEW and ST_MIX_SUM; session averages skip the blend, overflows the divider.
// a waiting result sits in the output register while the next request is taken.
// rst is synchronous; the ring needs no clearing, the fill count covers it.
module sliding_window_event_rate_meter import swerm_pkg::*; #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [TS_W-1:0]       timestamp_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RATE_W-1:0]     rate,
  output logic [CNT_W-1:0]      event_count,
  output logic                  reliable,
  output logic [TS_W-1:0]       session_ms,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);

  state_t state, state_next;

  logic [WS_W-1:0]   window_seconds;
  logic [MS_W-1:0]   min_services;
  logic [RATE_W-1:0] default_rate;
  logic [SW_W-1:0]   smoothing_weight;

  logic [TS_W-1:0]   ts_reg;
  logic [TS_W-1:0]   session_start;
  logic [CNT_W-1:0]  total_events;
  logic [RATE_W-1:0] rate_est;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] scan_k;
  logic [FILL_W-1:0] keep_n;
  logic              rd_pend;
  logic [TS_W-1:0]   first_stamp;
  logic              first_valid;
  logic [LIM_W-1:0]  lim;
  rate_mode_t        mode;
  logic [CNT_W-1:0]  x_reg;
  logic [PROD_W-1:0] prod;
  logic [TS_W-1:0]   div_sor;
  logic [TS_W-1:0]   rem;
  logic [DIV_BITS-1:0] dq;
  logic [DIV_CNT_W-1:0] bit_cnt;
  logic [MIX_W-2:0]  p_old;
  logic [MIX_W-2:0]  p_new;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [TS_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [TS_W-1:0]   rd_data;

  logic              in_acc;
  logic              scan_issue;
  logic              keep;
  logic              span_pos;
  logic              elapsed_pos;
  logic [CNT_W-1:0]  fill_ext;
  logic [CNT_W-1:0]  ms_ext;
  logic              fill_ok;
  logic              cnt_ok;
  logic              div_sat;
  logic [TS_W:0]     trial_in;
  logic [TS_W:0]     trial;
  logic              trial_ok;
  logic [SW_W-1:0]   w_eff;
  logic [MIX_W-1:0]  mix_sum;
  logic [RATE_W-1:0] rate_mix;
  logic              out_load;

  swerm_ram #(
    .WIDTH (TS_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign in_acc     = in_valid && in_ready;
  assign scan_issue = (state == ST_SCAN) && (scan_k < fill);
  // stamp stays when stamp + limit >= newest, i.e. stamp >= cutoff
  assign keep = ({1'b0, rd_data} + {{(TS_W + 1 - LIM_W){1'b0}}, lim}) >= {1'b0, ts_reg};
  assign span_pos    = ts_reg > first_stamp;
  assign elapsed_pos = ts_reg > session_start;
  assign fill_ext = {{(CNT_W - FILL_W){1'b0}}, fill};
  assign ms_ext   = {{(CNT_W - MS_W){1'b0}}, min_services};
  assign fill_ok  = fill_ext >= ms_ext;
  assign cnt_ok   = total_events >= ms_ext;
  // quotient overflows 32 bits when the upper dividend part reaches the divisor
  assign div_sat  = {{(TS_W - (PROD_W - FRAC_W)){1'b0}}, prod[PROD_W-1:FRAC_W]} >= div_sor;
  assign trial_in = {rem, dq[DIV_BITS-1]};
  assign trial    = trial_in - {1'b0, div_sor};
  assign trial_ok = trial_in >= {1'b0, div_sor};
  assign w_eff    = (smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : smoothing_weight;
  assign mix_sum  = {1'b0, p_old} + {1'b0, p_new} + {{(MIX_W - FRAC_W){1'b0}}, ROUND_HALF};
  assign rate_mix = (|mix_sum[MIX_W-1:RATE_W+FRAC_W]) ? '1 : mix_sum[RATE_W+FRAC_W-1:FRAC_W];
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (operation == OP_RESTART) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_issue && !rd_pend) begin
          state_next = ST_APPEND;
        end
      end
      ST_APPEND: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (fill_ok) begin
          state_next = span_pos ? ST_MUL : ST_DONE;
        end else if (cnt_ok) begin
          state_next = elapsed_pos ? ST_MUL : ST_DONE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MUL:      state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = div_sat ? ST_POST : ST_DIV;
      ST_DIV: begin
        if (bit_cnt == DIV_CNT_W'(DIV_BITS - 1)) begin
          state_next = ST_POST;
        end
      end
      ST_POST:     state_next = (mode == MODE_WINDOW) ? ST_MIX_OLD : ST_DONE;
      ST_MIX_OLD:  state_next = ST_MIX_NEW;
      ST_MIX_NEW:  state_next = ST_MIX_SUM;
      ST_MIX_SUM:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // handshake and ring port controls
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = keep_n[ADDR_W-1:0];
    ram_wdata = rd_data;
    ram_raddr = scan_k[ADDR_W-1:0];
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: ram_we = rd_pend && keep;
      ST_APPEND: begin
        ram_we    = 1'b1;
        ram_wdata = ts_reg;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      window_seconds   <= WINDOW_SECONDS_RST;
      min_services     <= MIN_SERVICES_RST;
      default_rate     <= DEFAULT_RATE_RST;
      smoothing_weight <= SMOOTHING_WEIGHT_RST;
      session_start    <= '0;
      total_events     <= '0;
      rate_est         <= DEFAULT_RATE_RST;
      fill             <= '0;
      rd_pend          <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          REG_WINDOW_SECONDS:   window_seconds   <= cfg_data[WS_W-1:0];
          REG_MIN_SERVICES:     min_services     <= cfg_data[MS_W-1:0];
          REG_DEFAULT_RATE:     default_rate     <= cfg_data[RATE_W-1:0];
          REG_SMOOTHING_WEIGHT: smoothing_weight <= cfg_data[SW_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            ts_reg <= timestamp_ms;
            if (operation == OP_RESTART) begin
              session_start <= timestamp_ms;
              total_events  <= '0;
              rate_est      <= default_rate;
              fill          <= '0;
            end else begin
              if (total_events != '1) begin
                total_events <= total_events + 1'b1;
              end
              lim <= LIM_W'(window_seconds) * LIM_W'(MS_PER_SEC);
              // a full ring drops its oldest stamp before the scan
              scan_k      <= (fill == FILL_FULL) ? FILL_W'(1) : '0;
              keep_n      <= '0;
              first_valid <= 1'b0;
              rd_pend     <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= scan_issue;
          if (scan_issue) begin
            scan_k <= scan_k + 1'b1;
          end
          if (rd_pend && keep) begin
            keep_n <= keep_n + 1'b1;
            if (!first_valid) begin
              first_stamp <= rd_data;
              first_valid <= 1'b1;
            end
          end
        end
        ST_APPEND: begin
          fill <= keep_n + 1'b1;
          if (!first_valid) begin
            first_stamp <= ts_reg;
          end
        end
        ST_DECIDE: begin
          if (fill_ok) begin
            mode    <= MODE_WINDOW;
            x_reg   <= {{(CNT_W - FILL_W){1'b0}}, fill - 1'b1};
            div_sor <= ts_reg - first_stamp;
          end else begin
            mode    <= MODE_SESSION;
            x_reg   <= total_events;
            div_sor <= ts_reg - session_start;
          end
        end
        ST_MUL: prod <= PROD_W'(x_reg) * PROD_W'(MS_PER_SEC);
        ST_DIV_INIT: begin
          rem     <= {{(TS_W - (PROD_W - FRAC_W)){1'b0}}, prod[PROD_W-1:FRAC_W]};
          bit_cnt <= '0;
          if (div_sat) begin
            dq <= '1;
          end else begin
            dq <= {prod[FRAC_W-1:0], {(DIV_BITS - FRAC_W){1'b0}}};
          end
        end
        ST_DIV: begin
          // dividend bits shift out the top, quotient bits in at the bottom
          dq      <= {dq[DIV_BITS-2:0], trial_ok};
          rem     <= trial_ok ? trial[TS_W-1:0] : trial_in[TS_W-1:0];
          bit_cnt <= bit_cnt + 1'b1;
        end
        ST_POST: begin
          if (mode == MODE_SESSION) begin
            rate_est <= dq;
          end
        end
        ST_MIX_OLD: p_old <= (MIX_W - 1)'(WEIGHT_ONE - w_eff) * (MIX_W - 1)'(rate_est);
        ST_MIX_NEW: p_new <= (MIX_W - 1)'(w_eff) * (MIX_W - 1)'(dq);
        ST_MIX_SUM: rate_est <= rate_mix;
        default: begin
        end
      endcase
    end
  end

  // result register, no reset needed on payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      rate        <= rate_est;
      event_count <= total_events;
      reliable    <= fill_ok || cnt_ok;
      session_ms  <= ts_reg - session_start;
    end
  end

endmodule

// ===== hdl/swerm_checker.sv =====
// port level checks of the sliding window event rate meter, bound to the top level
module swerm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] rate,
  input logic [31:0] event_count,
  input logic [31:0] session_ms
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rate) && $stable(event_count)
      && $stable(session_ms))
    else $error("stalled result changed");

  // one request in flight at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // only a restart gives a zero count, and it starts the session clock
  a_restart_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_count == 32'd0) |-> session_ms == 32'd0)
    else $error("zero count with nonzero session time");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sliding_window_event_rate_meter swerm_checker u_swerm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .rate        (rate),
  .event_count (event_count),
  .session_ms  (session_ms)
);

// ===== sim/rate_meter_checker.sv =====
// rate meter checker: tracks register writes and requests, predicts each result, compares
module rate_meter_checker
  import swerm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  operation,
  input  logic [TS_W-1:0]       timestamp_ms,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [RATE_W-1:0]     rate,
  input  logic [CNT_W-1:0]      event_count,
  input  logic                  reliable,
  input  logic [TS_W-1:0]       session_ms,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    compared
);

  localparam int STAMP_SLOTS = 16;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [CNT_W-1:0]  count;
    logic              reliable;
    logic [TS_W-1:0]   session;
  } meter_result_t;

  // register copies
  logic [WS_W-1:0]   age_limit_s;
  logic [MS_W-1:0]   min_count;
  logic [RATE_W-1:0] restart_rate;
  logic [SW_W-1:0]   blend_weight;

  // meter state, stamps kept oldest first
  logic [TS_W-1:0]   recent_stamps[$];
  logic [TS_W-1:0]   session_origin;
  logic [CNT_W-1:0]  tally;
  logic [RATE_W-1:0] rate_q;

  meter_result_t awaited_results[$];

  function automatic logic [31:0] clip32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic meter_result_t advance_meter(logic op, logic [TS_W-1:0] ts);
    meter_result_t r;
    logic [TS_W-1:0] kept[$];
    longint cutoff, span, elapsed;
    logic [63:0] quot, w, mix;
    if (op == OP_RESTART) begin
      session_origin = ts;
      tally = '0;
      rate_q = restart_rate;
      recent_stamps.delete();
    end else begin
      if (tally != 32'hFFFF_FFFF) tally++;
      if (recent_stamps.size() >= STAMP_SLOTS) void'(recent_stamps.pop_front());
      recent_stamps = {recent_stamps, ts};
      // signed ages, no wraparound of the stamps
      cutoff = longint'(ts) - longint'(age_limit_s) * 1000;
      foreach (recent_stamps[k])
        if (longint'(recent_stamps[k]) >= cutoff) kept = {kept, recent_stamps[k]};
      recent_stamps = kept;
      if (recent_stamps.size() >= int'(min_count) && recent_stamps.size() > 0) begin
        span = longint'(recent_stamps[$]) - longint'(recent_stamps[0]);
        if (span > 0) begin
          quot = 64'(recent_stamps.size() - 1) * 64'd65536000 / 64'(span);
          w = (blend_weight > WEIGHT_ONE) ? 64'd65536 : 64'(blend_weight);
          mix = (64'd65536 - w) * 64'(rate_q) + w * 64'(clip32(quot)) + 64'd32768;
          rate_q = clip32(mix >> 16);
        end
      end else if (tally >= 32'(min_count)) begin
        elapsed = longint'(ts) - longint'(session_origin);
        if (elapsed > 0) rate_q = clip32(64'(tally) * 64'd65536000 / 64'(elapsed));
      end
    end
    r.rate = rate_q;
    r.count = tally;
    r.reliable = (recent_stamps.size() >= int'(min_count)) || (tally >= 32'(min_count));
    r.session = ts - session_origin;
    return r;
  endfunction

  always @(posedge clk) begin
    meter_result_t got, want;
    if (rst) begin
      age_limit_s = WINDOW_SECONDS_RST;
      min_count = MIN_SERVICES_RST;
      restart_rate = DEFAULT_RATE_RST;
      blend_weight = SMOOTHING_WEIGHT_RST;
      recent_stamps.delete();
      session_origin = '0;
      tally = '0;
      rate_q = DEFAULT_RATE_RST;
      awaited_results.delete();
      fail_count = 0;
      compared = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WINDOW_SECONDS:   age_limit_s = cfg_data[WS_W-1:0];
          REG_MIN_SERVICES:     min_count = cfg_data[MS_W-1:0];
          REG_DEFAULT_RATE:     restart_rate = cfg_data[RATE_W-1:0];
          REG_SMOOTHING_WEIGHT: blend_weight = cfg_data[SW_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        awaited_results = {awaited_results, advance_meter(operation, timestamp_ms)};
      if (out_valid && out_ready) begin
        got = '{rate, event_count, reliable, session_ms};
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: rate %h count %0d reliable %b session %0d",
                     rate, event_count, reliable, session_ms);
        end else begin
          want = awaited_results.pop_front();
          compared++;
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch on result %0d: rate %h/%h count %0d/%0d reliable %b/%b ",
                        "session %0d/%0d (expected/actual)"}, compared,
                       want.rate, got.rate, want.count, got.count,
                       want.reliable, got.reliable, want.session, got.session);
          end
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// testbench top: stimulus, register writes and verdict for the rate meter
module tb_top import swerm_pkg::*; ();

  localparam int RUN_LIMIT      = 1_500_000;
  localparam int PHASES         = 8;
  localparam int RANDOM_PER_SET = 233;
  localparam int SQUEEZE_AFTER  = 300;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 80;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  operation;
  logic [TS_W-1:0]       timestamp_ms;
  logic                  out_valid;
  logic                  out_ready;
  logic [RATE_W-1:0]     rate;
  logic [CNT_W-1:0]      event_count;
  logic                  reliable;
  logic [TS_W-1:0]       session_ms;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count, pending, compared;
  int sent, restarts, cycles;
  logic sender_calm;
  logic [WS_W-1:0] cur_window;

  sliding_window_event_rate_meter u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .timestamp_ms (timestamp_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rate         (rate),
    .event_count  (event_count),
    .reliable     (reliable),
    .session_ms   (session_ms),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rate_meter_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .timestamp_ms (timestamp_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rate         (rate),
    .event_count  (event_count),
    .reliable     (reliable),
    .session_ms   (session_ms),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .compared     (compared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // time advance between events, scale 0 piles many events into one ms
  function automatic logic [TS_W-1:0] advance_ms(int scale, logic [WS_W-1:0] ws);
    case (scale)
      0:       return ($urandom_range(0, 199) == 0) ? 32'd1 : 32'd0;
      1:       return 32'($urandom_range(0, 20));
      2:       return 32'($urandom_range(0, 1000));
      default: return 32'($urandom_range(0, int'(ws) * 1000 + 2000));
    endcase
  endfunction

  task automatic push_event(input logic op, input logic [TS_W-1:0] ts);
    int gap, r;
    gap = 0;
    if (!sender_calm) begin
      r = $urandom_range(0, 99);
      if (r >= 97) gap = $urandom_range(20, 80);
      else if (r >= 90) gap = $urandom_range(4, 10);
      else if (r >= 65) gap = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    timestamp_ms <= ts;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (op == OP_RESTART) restarts++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // junk above each register's width must be dropped
  task automatic load_settings(input logic [WS_W-1:0] ws, input logic [MS_W-1:0] ms,
                               input logic [RATE_W-1:0] dr, input logic [SW_W-1:0] sw);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_WINDOW_SECONDS;
    cfg_data <= ($urandom & ~32'hFFF) | 32'(ws);
    @(negedge clk);
    cfg_index <= REG_MIN_SERVICES;
    cfg_data <= ($urandom & ~32'h1FF) | 32'(ms);
    @(negedge clk);
    cfg_index <= REG_DEFAULT_RATE;
    cfg_data <= dr;
    @(negedge clk);
    cfg_index <= REG_SMOOTHING_WEIGHT;
    cfg_data <= ($urandom & ~32'h1FFFF) | 32'(sw);
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_window = ws;
  endtask

  initial begin : receiver
    int hold, calm_left, r;
    logic squeezed, calm;
    hold = 0;
    calm_left = 0;
    squeezed = 1'b0;
    calm = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 300);
      end else begin
        calm_left--;
      end
      // one long hold-off so the output backs up into the input
      if (!squeezed && sent >= SQUEEZE_AFTER) begin
        squeezed = 1'b1;
        hold = SQUEEZE_CYCLES;
      end else if (hold == 0 && !calm) begin
        r = $urandom_range(0, 99);
        if (r >= 97) hold = $urandom_range(20, 80);
        else if (r >= 85) hold = $urandom_range(1, 3);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int p, n, r, scale, restart_pct;
    logic [TS_W-1:0] cursor;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_RECORD;
    timestamp_ms = '0;
    cfg_write = 1'b0;
    cfg_index = REG_WINDOW_SECONDS;
    cfg_data = '0;
    sent = 0;
    restarts = 0;
    sender_calm = 1'b0;
    cur_window = WINDOW_SECONDS_RST;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed requests under the register values after reset
    push_event(OP_RECORD, 32'd5);
    push_event(OP_RESTART, 32'd1000);
    push_event(OP_RECORD, 32'd1000);
    push_event(OP_RECORD, 32'd1000);
    push_event(OP_RECORD, 32'd1000);      // enough stamps but zero span
    push_event(OP_RECORD, 32'd1250);
    push_event(OP_RECORD, 32'd1100);      // out of order
    push_event(OP_RECORD, 32'd30000);     // everything else ages out
    push_event(OP_RECORD, 32'd30001);
    push_event(OP_RECORD, 32'd30001);
    push_event(OP_RECORD, 32'd29000);
    push_event(OP_RESTART, 32'hFFFF_FF00);
    push_event(OP_RECORD, 32'hFFFF_FFFF);
    push_event(OP_RECORD, 32'd0);         // session time wraps, elapsed negative
    push_event(OP_RECORD, 32'd5);
    push_event(OP_RECORD, 32'h8000_0000);
    push_event(OP_RESTART, 32'd0);
    push_event(OP_RECORD, 32'd0);
    push_event(OP_RECORD, 32'd0);
    push_event(OP_RECORD, 32'd0);
    push_event(OP_RECORD, 32'd2);

    for (p = 1; p < PHASES; p++) begin
      drain();
      restart_pct = 3;
      scale = 3;
      case (p)
        1: load_settings(12'd4095, 9'd1, 32'd0, 17'd0);
        2: load_settings(12'd0, 9'd0, 32'hFFFF_FFFF, WEIGHT_ONE);
        3: load_settings(12'd1, 9'd511, $urandom, 17'h1FFFF);
        4: begin
          // dense bursts push the session average into saturation
          load_settings(12'd2, 9'd20, $urandom, 17'($urandom_range(0, 131071)));
          restart_pct = 1;
          scale = 0;
        end
        default: load_settings(($urandom_range(0, 1) == 0) ? 12'($urandom_range(1, 10))
                                                             : 12'($urandom_range(0, 4095)),
                               9'($urandom_range(0, 18)), $urandom,
                               17'($urandom_range(0, 131071)));
      endcase
      cursor = $urandom;
      push_event(OP_RESTART, cursor);
      for (n = 0; n < RANDOM_PER_SET; n++) begin
        if (n % 40 == 0) begin
          if (p != 4) scale = $urandom_range(0, 3);
          sender_calm = ($urandom_range(0, 3) == 0);
        end
        r = $urandom_range(0, 99);
        if (r < restart_pct) begin
          case ($urandom_range(0, 3))
            0: cursor = $urandom;
            1: cursor = 32'hFFFF_F000 + 32'($urandom_range(0, 4095));
            default: ;
          endcase
          push_event(OP_RESTART, cursor);
        end else if (r < restart_pct + 3) begin
          push_event(OP_RECORD, $urandom);
        end else if (r < restart_pct + 6) begin
          push_event(OP_RECORD, cursor - 32'($urandom_range(0, 500)));
        end else begin
          cursor = cursor + advance_ms(scale, cur_window);
          push_event(OP_RECORD, cursor);
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d requests (%0d restarts) under %0d register settings, %0d results checked",
             sent, restarts, PHASES, compared);
    $display("receiver held off %0d cycles once to back up the input", SQUEEZE_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
